[rtl/smsk_pkg.sv]
// Package: widths, item and control types, state codes and key compare for the sorter.
`timescale 1ns / 1ps
package smsk_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int KEY_W     = 32;
  localparam int TAG_W     = 6;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int DRN_W     = $clog2(MAX_ITEMS);

  // one stored entry: key plus load position
  typedef struct packed {
    logic               valid;
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]   tag;
  } item_t;

  // control from the sequencer to every cell
  typedef struct packed {
    logic shift;   // move every entry one cell toward the head
  } chain_ctl_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // strict order on (key, tag); tags are unique, so ties in key resolve by load order
  function automatic logic item_less(input item_t a, input item_t b);
    logic res;
    if (a.key != b.key) begin
      res = (a.key < b.key);
    end else begin
      res = (a.tag < b.tag);
    end
    return res;
  endfunction

endpackage

[rtl/smsk_if.sv]
// Channel interfaces: key input and sorted result output.
`timescale 1ns / 1ps
interface smsk_in_if import smsk_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] key;
  logic                    last;

  modport source (output valid, output key, output last, input ready);
  modport sink   (input valid, input key, input last, output ready);
endinterface

interface smsk_out_if import smsk_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] sorted_key;
  logic [TAG_W-1:0]        origin_index;
  logic                    final_res;
  logic                    overflowed;

  modport source (output valid, output sorted_key, output origin_index,
                  output final_res, output overflowed, input ready);
  modport sink   (input valid, input sorted_key, input origin_index,
                  input final_res, input overflowed, output ready);
endinterface

[rtl/smsk_cell.sv]
// Sorter cell: keeps smaller of held and incoming, passes the other; shift takes right's entry.
`timescale 1ns / 1ps
module smsk_cell import smsk_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  chain_ctl_t ctl,
  input  item_t      ins,    // from left neighbor's pass register
  input  item_t      right,  // right neighbor's held entry, for shift-out
  output item_t      held,
  output item_t      pass
);

  item_t held_next;
  item_t pass_next;

  always_comb begin
    held_next = held;
    pass_next = ins;
    pass_next.valid = 1'b0;
    if (ctl.shift) begin
      held_next = right;
    end else if (ins.valid) begin
      if (!held.valid) begin
        held_next = ins;
      end else if (item_less(ins, held)) begin
        held_next = ins;
        pass_next = held;
      end else begin
        pass_next = ins;
      end
    end
  end

  // valid bits reset; key and tag carry no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid <= 1'b0;
      pass.valid <= 1'b0;
    end else begin
      held.valid <= held_next.valid;
      pass.valid <= pass_next.valid;
    end
    held.key <= held_next.key;
    held.tag <= held_next.tag;
    pass.key <= pass_next.key;
    pass.tag <= pass_next.tag;
  end

endmodule

[rtl/smsk_chain.sv]
// Row of MAX_ITEMS sorter cells; new entries enter at the head, results leave at the head.
`timescale 1ns / 1ps
module smsk_chain import smsk_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  chain_ctl_t ctl,
  input  item_t      head_in,
  output item_t      head
);

  item_t held [MAX_ITEMS];
  item_t pass [MAX_ITEMS];

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    item_t ins_i;
    item_t right_i;

    if (i == 0) begin : g_first
      assign ins_i = head_in;
    end else begin : g_mid
      assign ins_i = pass[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_last
      assign right_i = '0;
    end else begin : g_inner
      assign right_i = held[i+1];
    end

    smsk_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl),
      .ins   (ins_i),
      .right (right_i),
      .held  (held[i]),
      .pass  (pass[i])
    );
  end

  assign head = held[0];

endmodule

[rtl/stable_merge_sort_by_key_top.sv]
// Top level: stable key sorter with load-position tags, built on a systolic cell chain.
// Operation: n keys are loaded, then the chain settles in the drain state after the last
//   transaction, then one result per cycle while the sink is ready.
// A new set is accepted only after the last result of the previous set has been taken.
// Reset (rst, synchronous, active high): empties every cell, clears count and overflow,
//   returns to loading; stored keys and tags need no reset.
`timescale 1ns / 1ps
module stable_merge_sort_by_key_top import smsk_pkg::*; (
  input logic           clk,
  input logic           rst,
  smsk_in_if.sink       load,
  smsk_out_if.source    result
);

  // Sequencer state
  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  count;       // keys stored in this set
  logic              ovf;         // a key was dropped in this set
  logic [DRN_W-1:0]  drain_cnt;   // settle timer after the last key
  logic [CNT_W-1:0]  remaining;   // results still to deliver

  logic       load_fire;
  logic       result_fire;
  logic       drain_done;
  logic       emit_done;
  chain_ctl_t ctl;
  item_t      head_in;
  item_t      head;

  assign load_fire   = load.valid && load.ready;
  assign result_fire = result.valid && result.ready;
  assign drain_done  = (drain_cnt == DRN_W'(MAX_ITEMS - 1));
  assign emit_done   = result_fire && (remaining == CNT_W'(1));

  // Next-state logic
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (load_fire && load.last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (drain_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_done) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // Output logic
  always_comb begin
    load.ready   = 1'b0;
    result.valid = 1'b0;
    ctl.shift    = 1'b0;
    case (state)
      ST_LOAD:  load.ready = 1'b1;
      ST_DRAIN: ;
      ST_EMIT: begin
        result.valid = 1'b1;
        ctl.shift    = result.ready;  // pop the head, everything moves up one cell
      end
      default: ;
    endcase
  end

  // Insert into the head cell while there is room; tag is the load position
  always_comb begin
    head_in.valid = load_fire && (count < CNT_W'(MAX_ITEMS));
    head_in.key   = load.key;
    head_in.tag   = count[TAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      ovf       <= 1'b0;
      drain_cnt <= '0;
      remaining <= '0;
    end else begin
      state <= state_next;
      if (load_fire) begin
        if (count < CNT_W'(MAX_ITEMS)) count <= count + CNT_W'(1);
        else                           ovf   <= 1'b1;
      end
      if (state == ST_DRAIN) drain_cnt <= drain_cnt + DRN_W'(1);
      else                   drain_cnt <= '0;
      if (state == ST_DRAIN && drain_done) remaining <= count;
      else if (result_fire)                remaining <= remaining - CNT_W'(1);
      if (emit_done) begin
        count <= '0;
        ovf   <= 1'b0;
      end
    end
  end

  // Cell chain: insertion wave ripples down one cell a cycle; smallest entry sits at the head
  smsk_chain u_chain (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .head_in (head_in),
    .head    (head)
  );

  // Results come straight from the head cell's registers
  assign result.sorted_key   = head.key;
  assign result.origin_index = head.tag;
  assign result.final_res    = (remaining == CNT_W'(1));
  assign result.overflowed   = ovf;

`ifndef SYNTHESIS
  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> head.valid)
    else $error("result offered from an empty head cell");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(load.ready && result.valid))
    else $error("loading and emitting at once");

  a_set_cleared: assert property (@(posedge clk) disable iff (rst)
    emit_done |=> (state == ST_LOAD) && (count == '0) && !ovf)
    else $error("set not cleared after final result");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    ovf |-> (count == CNT_W'(MAX_ITEMS)))
    else $error("overflow flagged with free capacity");
`endif

endmodule

[tb/testbench.sv]
// Testbench for the stable key sorter: directed and random key sets checked by a scoreboard.
`timescale 1ns / 1ps
module testbench import smsk_pkg::*; ();

  // Idle-cycle watchdog limit; the longest legal quiet spell is the receiver hold plus
  // the chain settle time, well below this.
  localparam int WATCHDOG_LIMIT = 4000;
  // Receiver hold-off for the pressure test, long enough for a full set to settle and
  // back up behind a stalled output while the next set is offered.
  localparam int HOLD_CYCLES    = 400;
  // Quiet time after the last expected result, covers settle latency of a stray set.
  localparam int TAIL_CYCLES    = 140;
  localparam int MAX_REPORTS    = 10;

  // One stored key with its load position.
  typedef struct {
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
  } keyed_entry_t;

  // One result transaction as seen on the output channel.
  typedef struct {
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
    logic                    final_res;
    logic                    overflowed;
  } sorted_result_t;

  // Scoreboard: keeps the set being loaded in stable sorted order and releases the
  // expected burst when the last key of the set is accepted.
  class sort_scoreboard;
    keyed_entry_t   set_order[$];   // current set, already in output order
    int             loaded;         // keys stored in the current set
    bit             dropped;        // a key was lost to capacity in this set
    sorted_result_t sorted_q[$];    // expected results, oldest first
    int             mismatches;
    int             results_checked;
    int             keys_seen;
    int             sets_closed;
    int             overflow_sets;

    function void note_key(logic signed [KEY_W-1:0] key, logic last);
      keyed_entry_t   ent;
      sorted_result_t res;
      int             pos;
      keys_seen++;
      if (loaded < MAX_ITEMS) begin
        ent.key = key;
        ent.tag = TAG_W'(loaded);
        // insert after every stored key that is not greater: equal keys keep load order
        pos = set_order.size();
        while (pos > 0 && set_order[pos-1].key > key) pos--;
        set_order.insert(pos, ent);
        loaded++;
      end else begin
        dropped = 1'b1;
      end
      if (last) begin
        foreach (set_order[i]) begin
          res.key        = set_order[i].key;
          res.tag        = set_order[i].tag;
          res.final_res  = (i == set_order.size() - 1);
          res.overflowed = dropped;
          sorted_q.push_back(res);
        end
        sets_closed++;
        if (dropped) overflow_sets++;
        set_order.delete();
        loaded  = 0;
        dropped = 1'b0;
      end
    endfunction

    function void report(string what, sorted_result_t exp, sorted_result_t got);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("[%0t] %s: expected key %0d tag %0d final %0b ovf %0b,",
                 $time, what, exp.key, exp.tag, exp.final_res, exp.overflowed);
        $display("        got key %0d tag %0d final %0b ovf %0b",
                 got.key, got.tag, got.final_res, got.overflowed);
      end
    endfunction

    function void check_result(sorted_result_t got);
      sorted_result_t exp;
      results_checked++;
      if (sorted_q.size() == 0) begin
        exp = '{default: '0};
        report("unexpected result", exp, got);
      end else begin
        exp = sorted_q.pop_front();
        if (got.key !== exp.key || got.tag !== exp.tag ||
            got.final_res !== exp.final_res || got.overflowed !== exp.overflowed)
          report("wrong result", exp, got);
      end
    endfunction

    function void close_out();
      if (sorted_q.size() != 0) begin
        mismatches += sorted_q.size();
        $display("%0d expected results never arrived", sorted_q.size());
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  smsk_in_if  load_ch ();
  smsk_out_if result_ch ();

  stable_merge_sort_by_key_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .load   (load_ch),
    .result (result_ch)
  );

  sort_scoreboard sb;

  // Idle controls, written by the stimulus with nonblocking assignments.
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;

  // Owned by the receiver process alone.
  int hold_left;
  bit hold_done;

  int idle_cycles;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Receiver: random backpressure, plus one long hold-off when requested.
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: both channels sampled at the edge, before this edge's updates land.
  always @(posedge clk) begin
    sorted_result_t got;
    if (!rst) begin
      if (load_ch.valid && load_ch.ready)
        sb.note_key(load_ch.key, load_ch.last);
      if (result_ch.valid && result_ch.ready) begin
        got.key        = result_ch.sorted_key;
        got.tag        = result_ch.origin_index;
        got.final_res  = result_ch.final_res;
        got.overflowed = result_ch.overflowed;
        sb.check_result(got);
      end
    end
  end

  // Watchdog: counts cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (rst || (load_ch.valid && load_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", idle_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offers one key and returns at the edge where it is accepted; valid stays high
  // so back-to-back keys go out without a bubble unless a gap is drawn.
  task automatic send_key(input logic signed [KEY_W-1:0] key, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      load_ch.valid <= 1'b0;
      @(posedge clk);
    end
    load_ch.valid <= 1'b1;
    load_ch.key   <= key;
    load_ch.last  <= last;
    @(posedge clk);
    while (!load_ch.ready) @(posedge clk);
  endtask

  // Mix of wide random keys, two narrow ranges for ties, and the signed extremes, zero and -1.
  function automatic logic signed [KEY_W-1:0] rand_key();
    logic signed [KEY_W-1:0] k;
    case ($urandom_range(0, 3))
      0: k = $urandom;
      1: k = KEY_W'($urandom_range(0, 6)) - 3;
      2: begin
        case ($urandom_range(0, 3))
          0: k = 32'sh7FFF_FFFF;
          1: k = 32'sh8000_0000;
          2: k = '0;
          default: k = '1;
        endcase
      end
      default: k = KEY_W'($urandom_range(0, 255)) - 128;
    endcase
    return k;
  endfunction

  // Random small sets until at least n_keys keys have gone out.
  task automatic send_random_sets(input int n_keys);
    int sent;
    int set_len;
    sent = 0;
    while (sent < n_keys) begin
      set_len = $urandom_range(1, 10);
      for (int i = 0; i < set_len; i++) send_key(rand_key(), i == set_len - 1);
      sent += set_len;
    end
  endtask

  // Directed sets: signed extremes with ties, a single-key set, all-equal keys,
  // and a strictly descending run.
  localparam int N_DIRECTED = 18;
  localparam logic signed [KEY_W-1:0] DIR_KEYS [N_DIRECTED] = '{
    32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, -32'sd1, 32'sd1, 32'sh8000_0000,
    32'sh7FFF_FFFF, 32'sh0,
    32'sd5,
    -32'sd7, -32'sd7, -32'sd7, -32'sd7,
    32'sd40, 32'sd30, 32'sd20, 32'sd10, 32'sd0
  };
  localparam logic DIR_LAST [N_DIRECTED] = '{
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
    1'b1,
    1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b1
  };

  initial begin
    sb              = new();
    rst             = 1'b1;
    load_ch.valid   = 1'b0;
    load_ch.key     = '0;
    load_ch.last    = 1'b0;
    result_ch.ready = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_req        = 1'b0;
    hold_left       = 0;
    hold_done       = 1'b0;
    idle_cycles     = 0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) send_key(DIR_KEYS[i], DIR_LAST[i]);

    // random sets under each idle pattern
    send_random_sets(4);
    send_idle_pct <= 88;
    send_random_sets(4);
    send_idle_pct  <= 0;
    recv_stall_pct <= 88;
    send_random_sets(4);
    send_idle_pct  <= 11;
    recv_stall_pct <= 11;
    send_random_sets(4);

    // Pressure: hold the output off, push a set one past capacity whose last key is
    // the dropped one, then keep offering keys so the input backs up.
    send_idle_pct  <= 0;
    recv_stall_pct <= 0;
    hold_req       <= 1'b1;
    for (int i = 0; i <= MAX_ITEMS; i++) send_key(rand_key(), i == MAX_ITEMS);
    send_random_sets(1);
    load_ch.valid <= 1'b0;

    while (sb.sorted_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    sb.close_out();

    $display("Sorted %0d sets from %0d keys (%0d over capacity), %0d results checked.",
             sb.sets_closed, sb.keys_seen, sb.overflow_sets, sb.results_checked);
    $display("Idle patterns: none, sender, receiver, both, and one long receiver hold-off.");
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
